// File: rtl/core/ssir_pkg.sv
// ----------------------------------------------------------------------------
// ssir_pkg
// Shared types and codes for the sorted set insert/remove unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssir_pkg;

    // Request kinds; the unused code behaves as a find
    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_BELOW,
        RD_ABOVE
    } rd_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_INS_CHK,
        S_INS_WR,
        S_REM_CHK,
        S_REM_WR,
        S_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    scan_miss;
        logic    scan_hit;
        logic    decide;
        logic    ptr_ins;
        logic    ptr_rem;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_en;
        logic    wr_key;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_at_end;
        logic key_above;
        logic do_insert;
        logic do_remove;
        logic ptr_at_pos;
        logic rem_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ssir_if.sv
// ----------------------------------------------------------------------------
// ssir_if
// Request and response channel interfaces (valid/ready with payload).
// ----------------------------------------------------------------------------
`default_nettype none

interface ssir_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] key;

    modport source (output valid, kind, key, input ready);
    modport sink   (input valid, kind, key, output ready);
endinterface

interface ssir_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       was_present;
    logic [4:0] position;
    logic [4:0] count_after;

    modport source (output valid, status, was_present, position, count_after, input ready);
    modport sink   (input valid, status, was_present, position, count_after, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ssir_ctrl.sv
// ----------------------------------------------------------------------------
// ssir_ctrl
// Sequencer: linear search, then shift of the store for insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module ssir_ctrl
    import ssir_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = sts.idx_at_end ? S_DECIDE : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = sts.key_above ? S_SCAN_RD : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.do_insert)
                begin
                    state_next = S_INS_CHK;
                end
                else if (sts.do_remove)
                begin
                    state_next = S_REM_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_INS_CHK:
            begin
                state_next = sts.ptr_at_pos ? S_FINISH : S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_INS_CHK;
            end
            S_REM_CHK:
            begin
                state_next = sts.rem_last ? S_FINISH : S_REM_WR;
            end
            S_REM_WR:
            begin
                state_next = S_REM_CHK;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.rd_src = RD_IDX;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_SCAN_RD:
            begin
                if (sts.idx_at_end)
                begin
                    cmd.scan_miss = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_IDX;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.key_above)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.scan_hit = 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.decide  = 1'b1;
                cmd.ptr_ins = sts.do_insert;
                cmd.ptr_rem = sts.do_remove;
            end
            S_INS_CHK:
            begin
                if (sts.ptr_at_pos)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_BELOW;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_dec = 1'b1;
            end
            S_REM_CHK:
            begin
                if (sts.rem_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_ABOVE;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ssir_datapath.sv
// ----------------------------------------------------------------------------
// ssir_datapath
// Key store, search and shift pointers, key count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssir_datapath
    import ssir_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         req_kind,
    input  wire logic signed [31:0] req_key,
    input  wire dp_cmd_t            cmd,
    output dp_sts_t                 sts,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [1:0]              rsp_status,
    output logic                    rsp_was_present,
    output logic [4:0]              rsp_position,
    output logic [4:0]              rsp_count_after
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    logic [1:0]         kind_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] rdata_reg;

    logic [CW-1:0] idx_reg,   idx_next;
    logic [CW-1:0] pos_reg,   pos_next;
    logic [CW-1:0] ptr_reg,   ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          present_reg, present_next;
    status_t       status_reg,  status_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg;
    logic          out_present_reg;
    logic [4:0]    out_position_reg;
    logic [4:0]    out_count_reg;

    logic [CW-1:0]      below;
    logic [CW-1:0]      above;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               full;
    status_t            decided;

    assign below = ptr_reg - CW'(1);
    assign above = ptr_reg + CW'(1);
    assign full  = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        case (cmd.rd_src)
            RD_IDX:   rd_addr = idx_reg[AW-1:0];
            RD_BELOW: rd_addr = below[AW-1:0];
            RD_ABOVE: rd_addr = above[AW-1:0];
            default:  rd_addr = idx_reg[AW-1:0];
        endcase
    end

    assign wr_addr = cmd.wr_key ? pos_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = cmd.wr_key ? key_reg : rdata_reg;

    // Single write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_INSERT: decided = present_reg ? ST_DUP : (full ? ST_FULL : ST_DONE);
            KIND_REMOVE: decided = present_reg ? ST_DONE : ST_ABSENT;
            default:     decided = present_reg ? ST_DONE : ST_ABSENT;
        endcase
    end

    always_comb
    begin
        sts.idx_at_end = (idx_reg == count_reg);
        sts.key_above  = (rdata_reg < key_reg);
        sts.do_insert  = (kind_reg == KIND_INSERT) && !present_reg && !full;
        sts.do_remove  = (kind_reg == KIND_REMOVE) && present_reg;
        sts.ptr_at_pos = (ptr_reg == pos_reg);
        sts.rem_last   = (above >= count_reg);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        present_next   = present_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.scan_miss)
        begin
            pos_next     = idx_reg;
            present_next = 1'b0;
        end
        if (cmd.scan_hit)
        begin
            pos_next     = idx_reg;
            present_next = (rdata_reg == key_reg);
        end
        if (cmd.decide)
        begin
            status_next = decided;
        end
        if (cmd.ptr_ins)
        begin
            ptr_next = count_reg;
        end
        if (cmd.ptr_rem)
        begin
            ptr_next = pos_reg;
        end
        if (cmd.ptr_dec)
        begin
            ptr_next = below;
        end
        if (cmd.ptr_inc)
        begin
            ptr_next = above;
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            present_reg   <= 1'b0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            present_reg   <= present_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_kind;
            key_reg  <= req_key;
        end
        if (cmd.out_load)
        begin
            out_status_reg   <= status_reg;
            out_present_reg  <= present_reg;
            out_position_reg <= 5'(pos_reg);
            out_count_reg    <= 5'(count_reg);
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_was_present = out_present_reg;
    assign rsp_position    = out_position_reg;
    assign rsp_count_after = out_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/sorted_set_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_remove_unit
// Ordered set of distinct signed 32-bit keys with find, insert and remove.
// ----------------------------------------------------------------------------
// Keys live in a store with one write port and one registered read port,
// held in ascending order. One request is worked at a time: a linear search
// reads and then compares one entry at a time until it meets the first key
// not below the request key, then an insert moves the tail up and a remove
// moves it down with one read and one write per moved entry. The result sits
// in an output register, so it may wait on the response channel while the
// next request is searched; only that request's final step waits for it.
// Position and count are reported as 5-bit values.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_insert_remove_unit
    import ssir_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ssir_req_if.sink  req,
    ssir_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    ssir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_kind        (req.kind),
        .req_key         (req.key),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_was_present (rsp.was_present),
        .rsp_position    (rsp.position),
        .rsp_count_after (rsp.count_after)
    );

endmodule

`default_nettype wire
